// ===== rtl/core/mia_pkg.sv =====
// Shared constants and control/status types for the matrix inverse by adjugate block.
// No dependencies; used by mia_ctrl, mia_dp and matrix_inverse_by_adjugate.
`default_nettype none

package mia_pkg;

   localparam int MAX_ORDER = 6;
   localparam int CELLS     = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int SET_W     = MAX_ORDER;
   localparam int PART_D    = 1 << MAX_ORDER;
   localparam int ORD_W     = 3;
   localparam int ENTRY_W   = 8;
   localparam int ADJ_W     = 42;
   localparam int INV_W     = 48;
   localparam int DET_W     = 51;
   localparam int FRAC_W    = 16;
   localparam int NUM_W     = ADJ_W + FRAC_W;
   localparam int DCNT_W    = $clog2(NUM_W);

   typedef struct packed {
      logic                mat_we;
      logic [ADDR_W-1:0]   mat_waddr;
      logic                rd_en;
      logic [ADDR_W-1:0]   mat_raddr;
      logic [SET_W-1:0]    part_raddr;
      logic                part_zero;
      logic                part_we;
      logic [SET_W-1:0]    part_waddr;
      logic                mul_en;
      logic                acc_clear;
      logic                acc_one;
      logic                acc_en;
      logic                acc_sub;
      logic                det_load;
      logic                adj_load;
      logic                adj_neg;
      logic                div_start;
      logic                div_step;
      logic                fin_load;
   } cmd_type;

   typedef struct packed {
      logic singular;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/mia_dp.sv =====
// Datapath: matrix store, subset partial-determinant store, multiply-accumulate,
// restoring divider and Q16 saturation. Depends on mia_pkg.
`default_nettype none

module mia_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire mia_pkg::cmd_type                       cmd,
   input  wire logic signed [mia_pkg::ENTRY_W-1:0]     entry,
   output mia_pkg::sts_type                            sts,
   output logic signed [mia_pkg::ADJ_W-1:0]            adj_out,
   output logic signed [mia_pkg::INV_W-1:0]            inv_out,
   output logic signed [mia_pkg::DET_W-1:0]            det_out
);

   logic signed [mia_pkg::ENTRY_W-1:0] mat_mem [mia_pkg::CELLS];
   logic signed [mia_pkg::DET_W-1:0]   part_mem [mia_pkg::PART_D];

   logic signed [mia_pkg::ENTRY_W-1:0] mat_rd_ff;
   logic signed [mia_pkg::DET_W-1:0]   part_rd_ff;
   logic                               pzero_ff;
   logic signed [mia_pkg::DET_W-1:0]   prod_ff;
   logic signed [mia_pkg::DET_W-1:0]   acc_ff;
   logic signed [mia_pkg::DET_W-1:0]   det_ff;
   logic signed [mia_pkg::ADJ_W-1:0]   adj_ff;
   logic signed [mia_pkg::INV_W-1:0]   inv_ff;
   logic [mia_pkg::DET_W:0]            rem_ff;
   logic [mia_pkg::NUM_W-1:0]          quo_ff;
   logic [mia_pkg::DET_W-1:0]          den_ff;
   logic                               neg_ff;

   logic signed [mia_pkg::DET_W-1:0]   part_val;
   logic signed [mia_pkg::ENTRY_W+mia_pkg::DET_W-1:0] prod_full;
   logic signed [mia_pkg::NUM_W-1:0]   num_s;
   logic [mia_pkg::NUM_W-1:0]          num_mag;
   logic [mia_pkg::DET_W-1:0]          den_mag;
   logic [mia_pkg::DET_W:0]            trial;
   logic                               ge;
   logic signed [mia_pkg::INV_W-1:0]   sat_val;

   localparam logic signed [mia_pkg::INV_W-1:0] Q16_MAX = {1'b0, {(mia_pkg::INV_W-1){1'b1}}};
   localparam logic signed [mia_pkg::INV_W-1:0] Q16_MIN = {1'b1, {(mia_pkg::INV_W-1){1'b0}}};
   localparam logic [mia_pkg::NUM_W-1:0] NEG_LIMIT = mia_pkg::NUM_W'(1) << (mia_pkg::INV_W-1);

   // empty subset contributes a partial determinant of one
   assign part_val  = pzero_ff ? mia_pkg::DET_W'(1) : part_rd_ff;
   assign prod_full = mat_rd_ff * part_val;

   assign num_s   = {adj_ff, {mia_pkg::FRAC_W{1'b0}}};
   assign num_mag = num_s[mia_pkg::NUM_W-1] ? mia_pkg::NUM_W'(-num_s) : mia_pkg::NUM_W'(num_s);
   assign den_mag = det_ff[mia_pkg::DET_W-1] ? mia_pkg::DET_W'(-det_ff)
                                              : mia_pkg::DET_W'(det_ff);

   assign trial = {rem_ff[mia_pkg::DET_W-1:0], quo_ff[mia_pkg::NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      if (!neg_ff) begin
         if (|quo_ff[mia_pkg::NUM_W-1:mia_pkg::INV_W-1]) begin
            sat_val = Q16_MAX;
         end else begin
            sat_val = {1'b0, quo_ff[mia_pkg::INV_W-2:0]};
         end
      end else begin
         if (quo_ff > NEG_LIMIT) begin
            sat_val = Q16_MIN;
         end else begin
            sat_val = -$signed(quo_ff[mia_pkg::INV_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mat_we) begin
         mat_mem[cmd.mat_waddr] <= entry;
      end
      if (cmd.part_we) begin
         part_mem[cmd.part_waddr] <= acc_ff;
      end
      if (cmd.rd_en) begin
         mat_rd_ff  <= mat_mem[cmd.mat_raddr];
         part_rd_ff <= part_mem[cmd.part_raddr];
         pzero_ff   <= cmd.part_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_full[mia_pkg::DET_W-1:0];
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_one) begin
         acc_ff <= mia_pkg::DET_W'(1);
      end else if (cmd.acc_en) begin
         acc_ff <= cmd.acc_sub ? acc_ff - prod_ff : acc_ff + prod_ff;
      end
      if (cmd.adj_load) begin
         adj_ff <= cmd.adj_neg ? -acc_ff[mia_pkg::ADJ_W-1:0] : acc_ff[mia_pkg::ADJ_W-1:0];
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= num_mag;
         den_ff <= den_mag;
         neg_ff <= adj_ff[mia_pkg::ADJ_W-1] ^ det_ff[mia_pkg::DET_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[mia_pkg::NUM_W-2:0], ge};
      end
      if (cmd.fin_load) begin
         inv_ff <= sts.singular ? '0 : sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_ff <= '0;
      end else if (cmd.det_load) begin
         det_ff <= acc_ff;
      end
   end

   assign sts.singular = (det_ff == '0);
   assign adj_out      = adj_ff;
   assign inv_out      = inv_ff;
   assign det_out      = det_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mia_ctrl.sv =====
// Controller: load sequencing, subset-expansion determinant sequencer, divider
// stepping and result strobe. Depends on mia_pkg.
`default_nettype none

module mia_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          csr_valid,
   input  wire logic [mia_pkg::ORD_W-1:0]     csr_order,
   input  wire mia_pkg::sts_type              sts,
   output mia_pkg::cmd_type                   cmd,
   output logic                               busy,
   output logic                               csr_ready,
   output logic                               rsp_valid,
   output logic [mia_pkg::ORD_W-1:0]          rsp_row,
   output logic [mia_pkg::ORD_W-1:0]          rsp_col,
   output logic                               rsp_last_of_run
);

   localparam logic [3:0] ST_LOAD       = 4'd0;
   localparam logic [3:0] ST_SET_BEGIN  = 4'd1;
   localparam logic [3:0] ST_TERM_ISSUE = 4'd2;
   localparam logic [3:0] ST_TERM_WAIT  = 4'd3;
   localparam logic [3:0] ST_TERM_ACC   = 4'd4;
   localparam logic [3:0] ST_SET_END    = 4'd5;
   localparam logic [3:0] ST_RESULT     = 4'd6;
   localparam logic [3:0] ST_DIV_INIT   = 4'd7;
   localparam logic [3:0] ST_DIVIDE     = 4'd8;
   localparam logic [3:0] ST_FINISH     = 4'd9;
   localparam logic [3:0] ST_EMIT       = 4'd10;

   localparam logic [mia_pkg::ORD_W-1:0] NO_EXCL   = '1;
   localparam logic [mia_pkg::ORD_W-1:0] ORDER_MAX = mia_pkg::ORD_W'(mia_pkg::MAX_ORDER);

   logic [3:0]                      state_ff, state_in;
   logic [mia_pkg::ORD_W-1:0]       order_ff, order_in;
   logic [mia_pkg::ORD_W-1:0]       load_r_ff, load_r_in;
   logic [mia_pkg::ORD_W-1:0]       load_c_ff, load_c_in;
   logic                            phase_det_ff, phase_det_in;
   logic [mia_pkg::ORD_W-1:0]       k_ff, k_in;
   logic [mia_pkg::ORD_W-1:0]       exr_ff, exr_in;
   logic [mia_pkg::ORD_W-1:0]       exc_ff, exc_in;
   logic [mia_pkg::SET_W-1:0]       set_ff, set_in;
   logic [mia_pkg::ORD_W-1:0]       j_ff, j_in;
   logic [mia_pkg::ORD_W-1:0]       pos_ff, pos_in;
   logic [mia_pkg::ORD_W-1:0]       out_r_ff, out_r_in;
   logic [mia_pkg::ORD_W-1:0]       out_c_ff, out_c_in;
   logic [mia_pkg::DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic                            valid_ff, valid_in;

   logic [mia_pkg::ORD_W-1:0]       n_eff;
   logic [mia_pkg::ORD_W-1:0]       nm1;
   logic [mia_pkg::SET_W:0]         full_wide;
   logic [mia_pkg::SET_W-1:0]       full;
   logic [mia_pkg::ORD_W-1:0]       pc;
   logic [mia_pkg::ORD_W-1:0]       row_sub;
   logic [mia_pkg::ORD_W-1:0]       arow;
   logic [mia_pkg::ORD_W-1:0]       acol;
   logic [mia_pkg::SET_W-1:0]       jbit;
   logic [mia_pkg::SET_W-1:0]       rest;
   logic                            accept;
   logic                            last_out;

   always_comb begin
      if (order_ff == '0) begin
         n_eff = mia_pkg::ORD_W'(1);
      end else if (order_ff > ORDER_MAX) begin
         n_eff = ORDER_MAX;
      end else begin
         n_eff = order_ff;
      end
   end

   always_comb begin
      pc = '0;
      for (int b = 0; b < mia_pkg::SET_W; b++) begin
         pc = pc + mia_pkg::ORD_W'(set_ff[b]);
      end
   end

   assign nm1       = n_eff - mia_pkg::ORD_W'(1);
   assign full_wide = ((mia_pkg::SET_W+1)'(1) << k_ff) - (mia_pkg::SET_W+1)'(1);
   assign full      = full_wide[mia_pkg::SET_W-1:0];
   assign row_sub   = pc - mia_pkg::ORD_W'(1);
   // skip the excluded row and column of a minor
   assign arow      = row_sub + mia_pkg::ORD_W'(row_sub >= exr_ff);
   assign acol      = j_ff + mia_pkg::ORD_W'(j_ff >= exc_ff);
   assign jbit      = mia_pkg::SET_W'(1) << j_ff;
   assign rest      = set_ff & ~jbit;
   assign accept    = start && !busy;
   assign last_out  = (out_r_ff == nm1) && (out_c_ff == nm1);

   always_comb begin
      state_in     = state_ff;
      order_in     = order_ff;
      load_r_in    = load_r_ff;
      load_c_in    = load_c_ff;
      phase_det_in = phase_det_ff;
      k_in         = k_ff;
      exr_in       = exr_ff;
      exc_in       = exc_ff;
      set_in       = set_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      out_r_in     = out_r_ff;
      out_c_in     = out_c_ff;
      dcnt_in      = dcnt_ff;
      valid_in     = 1'b0;
      cmd          = '0;
      cmd.mat_waddr  = mia_pkg::ADDR_W'(load_r_ff) * mia_pkg::ADDR_W'(mia_pkg::MAX_ORDER)
                       + mia_pkg::ADDR_W'(load_c_ff);
      cmd.mat_raddr  = mia_pkg::ADDR_W'(arow) * mia_pkg::ADDR_W'(mia_pkg::MAX_ORDER)
                       + mia_pkg::ADDR_W'(acol);
      cmd.part_raddr = rest;
      cmd.part_zero  = (rest == '0);
      cmd.part_waddr = set_ff;
      cmd.acc_sub    = row_sub[0] ^ pos_ff[0];
      cmd.adj_neg    = out_r_ff[0] ^ out_c_ff[0];

      case (state_ff)
         ST_LOAD: begin
            if (csr_valid) begin
               order_in  = csr_order;
               load_r_in = '0;
               load_c_in = '0;
            end else if (accept) begin
               cmd.mat_we = 1'b1;
               if (load_c_ff == nm1) begin
                  load_c_in = '0;
                  if (load_r_ff == nm1) begin
                     load_r_in    = '0;
                     phase_det_in = 1'b1;
                     k_in         = n_eff;
                     exr_in       = NO_EXCL;
                     exc_in       = NO_EXCL;
                     set_in       = mia_pkg::SET_W'(1);
                     state_in     = ST_SET_BEGIN;
                  end else begin
                     load_r_in = load_r_ff + mia_pkg::ORD_W'(1);
                  end
               end else begin
                  load_c_in = load_c_ff + mia_pkg::ORD_W'(1);
               end
            end
         end
         ST_SET_BEGIN: begin
            j_in   = '0;
            pos_in = '0;
            if (k_ff == '0) begin
               cmd.acc_one = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               cmd.acc_clear = 1'b1;
               state_in      = ST_TERM_ISSUE;
            end
         end
         ST_TERM_ISSUE: begin
            if (j_ff == k_ff) begin
               state_in = ST_SET_END;
            end else if (|(set_ff & jbit)) begin
               cmd.rd_en = 1'b1;
               state_in  = ST_TERM_WAIT;
            end else begin
               j_in = j_ff + mia_pkg::ORD_W'(1);
            end
         end
         ST_TERM_WAIT: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_TERM_ACC;
         end
         ST_TERM_ACC: begin
            cmd.acc_en = 1'b1;
            pos_in     = pos_ff + mia_pkg::ORD_W'(1);
            j_in       = j_ff + mia_pkg::ORD_W'(1);
            state_in   = ST_TERM_ISSUE;
         end
         ST_SET_END: begin
            cmd.part_we = 1'b1;
            if (set_ff == full) begin
               state_in = ST_RESULT;
            end else begin
               set_in   = set_ff + mia_pkg::SET_W'(1);
               state_in = ST_SET_BEGIN;
            end
         end
         ST_RESULT: begin
            if (phase_det_ff) begin
               cmd.det_load = 1'b1;
               phase_det_in = 1'b0;
               out_r_in     = '0;
               out_c_in     = '0;
               k_in         = nm1;
               exr_in       = '0;
               exc_in       = '0;
               set_in       = mia_pkg::SET_W'(1);
               state_in     = ST_SET_BEGIN;
            end else begin
               cmd.adj_load = 1'b1;
               state_in     = sts.singular ? ST_FINISH : ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            dcnt_in       = '0;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + mia_pkg::DCNT_W'(1);
            if (dcnt_ff == mia_pkg::DCNT_W'(mia_pkg::NUM_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.fin_load = 1'b1;
            valid_in     = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (last_out) begin
               state_in = ST_LOAD;
            end else begin
               // adjugate (r,c) is the signed minor of element (c,r)
               if (out_c_ff == nm1) begin
                  out_c_in = '0;
                  out_r_in = out_r_ff + mia_pkg::ORD_W'(1);
                  exr_in   = '0;
                  exc_in   = out_r_ff + mia_pkg::ORD_W'(1);
               end else begin
                  out_c_in = out_c_ff + mia_pkg::ORD_W'(1);
                  exr_in   = out_c_ff + mia_pkg::ORD_W'(1);
                  exc_in   = out_r_ff;
               end
               set_in   = mia_pkg::SET_W'(1);
               state_in = ST_SET_BEGIN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         order_ff     <= ORDER_MAX;
         load_r_ff    <= '0;
         load_c_ff    <= '0;
         phase_det_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         load_r_ff    <= load_r_in;
         load_c_ff    <= load_c_in;
         phase_det_ff <= phase_det_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      exr_ff   <= exr_in;
      exc_ff   <= exc_in;
      set_ff   <= set_in;
      j_ff     <= j_in;
      pos_ff   <= pos_in;
      out_r_ff <= out_r_in;
      out_c_ff <= out_c_in;
      dcnt_ff  <= dcnt_in;
   end

   // a register write in the same cycle holds off requests
   assign busy            = (state_ff != ST_LOAD) || csr_valid;
   assign csr_ready       = (state_ff == ST_LOAD);
   assign rsp_valid       = valid_ff;
   assign rsp_row         = out_r_ff;
   assign rsp_col         = out_c_ff;
   assign rsp_last_of_run = last_out;

endmodule

`default_nettype wire

// ===== rtl/core/matrix_inverse_by_adjugate.sv =====
// Top level of the matrix inverse by adjugate block: controller plus datapath.
// Depends on mia_pkg, mia_ctrl and mia_dp.
//
// Usage: write csr_order (1..6; 0 acts as 1, above 6 as 6) through csr_valid/
// csr_ready while the block is idle; any write restarts loading, and busy is high
// in the cycle of a write. Matrix entries are presented on req_entry in row-major
// order, one request accepted on each clock with start high and busy low, so a
// matrix loads at one entry a cycle. The request completing the matrix raises busy.
// The block then expands the determinant over column subsets (each term is read,
// multiplied and accumulated in turn, skipped columns are stepped over),
// then for each element expands the order-1 minor the same way and runs
// a one-bit-per-cycle divider (58 steps, skipped when singular). Each of the
// order*order results is shown for exactly one cycle with rsp_valid high, row-
// major, last marked by rsp_last_of_run; the receiver cannot stall them. busy
// falls after the last result. Synchronous reset returns the order to 6,
// empties the load and clears the determinant.
`default_nettype none

module matrix_inverse_by_adjugate (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [mia_pkg::ENTRY_W-1:0]     req_entry,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mia_pkg::ORD_W-1:0]              csr_order,
   output logic                                        rsp_valid,
   output logic [mia_pkg::ORD_W-1:0]                   rsp_row,
   output logic [mia_pkg::ORD_W-1:0]                   rsp_col,
   output logic signed [mia_pkg::ADJ_W-1:0]            rsp_adjugate_entry,
   output logic signed [mia_pkg::INV_W-1:0]            rsp_inverse_q16,
   output logic signed [mia_pkg::DET_W-1:0]            rsp_determinant,
   output logic                                        rsp_singular,
   output logic                                        rsp_last_of_run
);

   mia_pkg::cmd_type cmd;
   mia_pkg::sts_type sts;

   mia_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .csr_valid       (csr_valid),
      .csr_order       (csr_order),
      .sts             (sts),
      .cmd             (cmd),
      .busy            (busy),
      .csr_ready       (csr_ready),
      .rsp_valid       (rsp_valid),
      .rsp_row         (rsp_row),
      .rsp_col         (rsp_col),
      .rsp_last_of_run (rsp_last_of_run)
   );

   mia_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .entry   (req_entry),
      .sts     (sts),
      .adj_out (rsp_adjugate_entry),
      .inv_out (rsp_inverse_q16),
      .det_out (rsp_determinant)
   );

   assign rsp_singular = sts.singular;

endmodule

`default_nettype wire
